### rtl/core/assert_macros.svh
// assertion helper macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ess_pkg.sv
// ---------------------------------------------------------------------------
// ess_pkg
// shared constants and helpers for the exponential unit
// ---------------------------------------------------------------------------
package ess_pkg;
  localparam int IN_W = 22;
  localparam int OUT_W = 64;
  localparam int WORK_BITS = 30;
  localparam int SUM_W = 32;
  localparam int EXP_W = 12;

  typedef logic signed [EXP_W-1:0] exp_t;

  // rounded multiply with WORK_BITS fraction bits; a horner step uses it twice: round(round(s*a)*r), then 1 +/- t
  function automatic logic [SUM_W-1:0] mul_round(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [2*SUM_W-1:0] p;
    p = {{SUM_W{1'b0}}, a} * {{SUM_W{1'b0}}, b} + (64'd1 << (WORK_BITS - 1));
    return p[WORK_BITS +: SUM_W];
  endfunction
endpackage

### rtl/core/exp_scaling_squaring_core.sv
// ---------------------------------------------------------------------------
// exp_scaling_squaring_core
// e to the x for a Q6.16 argument, unsigned Q48.16 result
// ---------------------------------------------------------------------------
// usage: drive x_value and raise start; a request is taken on any edge with
// start high (busy is tied low, the pipeline takes one request per cycle).
// each result appears on exp_value/overflow_flag for one cycle with done
// high. the pipeline holds an entry stage, two stages per horner term, a
// normalize stage, two stages per squaring and an output stage.
// throughput is one request per clock.
// reset (synchronous) clears all valid bits; in-flight requests are dropped.
// the receiver cannot stall, so results are never held back.
// arguments beyond the halving range give zero (negative) or saturation.
// ---------------------------------------------------------------------------
module exp_scaling_squaring_core #(
  parameter int TAYLOR_TERMS = 10,
  parameter int MAX_HALVINGS = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ess_pkg::IN_W-1:0] x_value,
  output logic                        done,
  output logic [ess_pkg::OUT_W-1:0]   exp_value,
  output logic                        overflow_flag
);
  localparam int MW = 4;
  localparam int NT = (TAYLOR_TERMS > 16) ? 16 : TAYLOR_TERMS;
  localparam int SW = ess_pkg::SUM_W;

  assign busy = 1'b0;

  // entry: magnitude, halving count, scaled argument
  logic [ess_pkg::IN_W:0] ax;
  logic neg_c, dom_c;
  logic [MW-1:0] m_c;
  logic [SW-1:0] axx_c;

  always_comb begin
    logic [47:0] lim;
    logic [47:0] t;
    int sh;
    neg_c = x_value[ess_pkg::IN_W-1];
    ax = neg_c ? (ess_pkg::IN_W+1)'(-{x_value[ess_pkg::IN_W-1], x_value})
               : {1'b0, x_value};
    m_c = MW'(MAX_HALVINGS);
    for (int k = MAX_HALVINGS; k >= 0; k--) begin
      lim = 48'd1 << (FRAC_BITS - 1 + k);
      if ({25'd0, ax} <= lim) m_c = MW'(k);
    end
    lim = 48'd1 << (FRAC_BITS - 1 + MAX_HALVINGS);
    dom_c = ({25'd0, ax} <= lim);
    sh = ess_pkg::WORK_BITS - FRAC_BITS - int'(m_c);
    if (sh >= 0) t = {25'd0, ax} << sh;
    else t = ({25'd0, ax} + (48'd1 << (-sh - 1))) >> (-sh);
    axx_c = t[SW-1:0];
  end

  logic v [NT+1];
  logic n [NT+1];
  logic d [NT+1];
  logic [MW-1:0] mm [NT+1];
  logic [SW-1:0] a [NT+1];
  logic [SW-1:0] s [NT+1];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= start;
    n[0] <= neg_c; d[0] <= dom_c; mm[0] <= m_c; a[0] <= axx_c;
    s[0] <= SW'(64'd1 << ess_pkg::WORK_BITS);
  end

  for (genvar g = 0; g < NT; g++) begin : g_horner
    ess_horner_stage #(.TERM(NT - g), .MW(MW)) u_h (
      .clk(clk), .rst(rst), .vin(v[g]), .neg_in(n[g]), .m_in(mm[g]),
      .axx_in(a[g]), .sum_in(s[g]), .dom_in(d[g]),
      .vout(v[g+1]), .neg_out(n[g+1]), .m_out(mm[g+1]), .axx_out(a[g+1]),
      .sum_out(s[g+1]), .dom_out(d[g+1]));
  end

  // normalize: sum lies in (0.5, 2) so one or two shifts set the top bit
  logic [SW-1:0] sn;
  logic hv [MAX_HALVINGS+1];
  logic hn [MAX_HALVINGS+1];
  logic hd [MAX_HALVINGS+1];
  logic [MW-1:0] hm [MAX_HALVINGS+1];
  logic [SW-1:0] hmt [MAX_HALVINGS+1];
  ess_pkg::exp_t he [MAX_HALVINGS+1];

  always_comb begin
    sn = s[NT];
    for (int k = 0; k < 8; k++) if (!sn[SW-1]) sn = {sn[SW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    logic [SW-1:0] q;
    int c;
    if (rst) hv[0] <= 1'b0;
    else hv[0] <= v[NT];
    q = s[NT];
    c = 0;
    for (int k = 0; k < 8; k++) if (!q[SW-1]) begin q = {q[SW-2:0], 1'b0}; c++; end
    hmt[0] <= sn;
    he[0] <= ess_pkg::exp_t'(-ess_pkg::WORK_BITS - c);
    hn[0] <= n[NT]; hd[0] <= d[NT]; hm[0] <= mm[NT];
  end

  for (genvar g = 0; g < MAX_HALVINGS; g++) begin : g_sq
    ess_square_stage #(.IDX(g), .MW(MW)) u_s (
      .clk(clk), .rst(rst), .vin(hv[g]), .m_in(hm[g]), .mant_in(hmt[g]),
      .e_in(he[g]), .neg_in(hn[g]), .dom_in(hd[g]),
      .vout(hv[g+1]), .m_out(hm[g+1]), .mant_out(hmt[g+1]), .e_out(he[g+1]),
      .neg_out(hn[g+1]), .dom_out(hd[g+1]));
  end

  // output shift and rounding
  always_ff @(posedge clk) begin
    ess_pkg::exp_t sc;
    logic [64:0] w;
    logic [63:0] res;
    logic ovf;
    int r;
    if (rst) done <= 1'b0;
    else done <= hv[MAX_HALVINGS];
    sc = he[MAX_HALVINGS] + ess_pkg::exp_t'(FRAC_BITS);
    w = {33'd0, hmt[MAX_HALVINGS]};
    ovf = 1'b0;
    res = '0;
    if (!hd[MAX_HALVINGS]) begin
      res = hn[MAX_HALVINGS] ? '0 : '1;
      ovf = !hn[MAX_HALVINGS];
    end else if (sc >= 0) begin
      if (sc > 32) begin
        res = '1; ovf = 1'b1;
      end else res = 64'(w << sc);
    end else if (-sc <= 33) begin
      r = -int'(sc);
      w = (w + (65'd1 << (r - 1))) >> r;
      res = w[63:0];
    end
    exp_value <= res;
    overflow_flag <= ovf;
  end
endmodule

### rtl/core/ess_horner_stage.sv
// ---------------------------------------------------------------------------
// ess_horner_stage
// one horner step for a fixed term index: a registered product, then a registered reciprocal multiply
// ---------------------------------------------------------------------------
module ess_horner_stage #(
  parameter int TERM = 1,
  parameter int MW = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vin,
  input  logic                      neg_in,
  input  logic [MW-1:0]             m_in,
  input  logic [ess_pkg::SUM_W-1:0] axx_in,
  input  logic [ess_pkg::SUM_W-1:0] sum_in,
  input  logic                      dom_in,
  output logic                      vout,
  output logic                      neg_out,
  output logic [MW-1:0]             m_out,
  output logic [ess_pkg::SUM_W-1:0] axx_out,
  output logic [ess_pkg::SUM_W-1:0] sum_out,
  output logic                      dom_out
);
  // rounded reciprocal of the term index in Q2.30
  localparam logic [ess_pkg::SUM_W-1:0] Rcp = ess_pkg::SUM_W'(
    ((64'd1 << ess_pkg::WORK_BITS) + 64'(TERM / 2)) / 64'(TERM));
  localparam logic [ess_pkg::SUM_W-1:0] One = 32'd1 << ess_pkg::WORK_BITS;
  // product stage then reciprocal stage
  logic [ess_pkg::SUM_W-1:0] p;
  logic v1, n1, d1;
  logic [MW-1:0] m1;
  logic [ess_pkg::SUM_W-1:0] a1, t;

  assign t = ess_pkg::mul_round(p, Rcp);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vout <= 1'b0;
    end else begin
      v1 <= vin;
      vout <= v1;
    end
    p <= ess_pkg::mul_round(sum_in, axx_in);
    n1 <= neg_in; m1 <= m_in; a1 <= axx_in; d1 <= dom_in;
    sum_out <= n1 ? One - t : One + t;
    neg_out <= n1; m_out <= m1; axx_out <= a1; dom_out <= d1;
  end
endmodule

### rtl/core/ess_square_stage.sv
// ---------------------------------------------------------------------------
// ess_square_stage
// one registered squaring of a normalized mantissa, skipped past count m
// ---------------------------------------------------------------------------
module ess_square_stage #(
  parameter int IDX = 0,
  parameter int MW = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      vin,
  input  logic [MW-1:0]             m_in,
  input  logic [ess_pkg::SUM_W-1:0] mant_in,
  input  ess_pkg::exp_t             e_in,
  input  logic                      neg_in,
  input  logic                      dom_in,
  output logic                      vout,
  output logic [MW-1:0]             m_out,
  output logic [ess_pkg::SUM_W-1:0] mant_out,
  output ess_pkg::exp_t             e_out,
  output logic                      neg_out,
  output logic                      dom_out
);
  logic [63:0] p, pn;
  logic [32:0] mr;
  logic v1, n1, d1, act;
  logic [MW-1:0] m1;
  logic [ess_pkg::SUM_W-1:0] mt1;
  ess_pkg::exp_t e1, ec;

  always_comb begin
    pn = p[63] ? p : {p[62:0], 1'b0};
    ec = ess_pkg::exp_t'(2 * e1 + 32) - (p[63] ? ess_pkg::exp_t'(0) : ess_pkg::exp_t'(1));
    mr = {1'b0, pn[63:32]} + {32'd0, pn[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vout <= 1'b0;
    end else begin
      v1 <= vin;
      vout <= v1;
    end
    p <= {32'd0, mant_in} * {32'd0, mant_in};
    act <= ({{(32-MW){1'b0}}, m_in} > 32'(IDX));
    m1 <= m_in; mt1 <= mant_in; e1 <= e_in; n1 <= neg_in; d1 <= dom_in;
    m_out <= m1; neg_out <= n1; dom_out <= d1;
    if (!act) begin
      mant_out <= mt1; e_out <= e1;
    end else if (mr[32]) begin
      mant_out <= mr[32:1]; e_out <= ec + ess_pkg::exp_t'(1);
    end else begin
      mant_out <= mr[31:0]; e_out <= ec;
    end
  end
endmodule

### rtl/core/ess_checker.sv
// ---------------------------------------------------------------------------
// ess_checker
// port-level checks on the exponential core
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ess_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [63:0] exp_value,
  input logic        overflow_flag
);
  `ASSERT_IMPL(a_ovf_sat, clk, rst, done && overflow_flag, exp_value == 64'hFFFF_FFFF_FFFF_FFFF, "overflow without saturation")
  `ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy, "pipeline reported busy")
  `ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !done, "done right after reset")
endmodule

bind exp_scaling_squaring_core ess_checker u_ess_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done),
  .exp_value(exp_value), .overflow_flag(overflow_flag));
